[hdl/tmcs_pkg.sv]
// shared types, constants and helper functions of the mip chain size block
package tmcs_pkg;

  localparam int DIM_BITS_DEF = 16;
  localparam int DIM_MAX      = 16;
  localparam int PROD_BITS    = 2 * DIM_MAX;
  localparam int ACC_BITS     = 35;
  localparam int SUM_BITS     = ACC_BITS + 4;
  localparam int FMT_BITS     = 6;
  localparam int LVL_BITS     = 8;

  localparam logic [ACC_BITS-1:0] BYTE_MAX = {ACC_BITS{1'b1}};

  // tile byte counts as shifts: 32 and 64 bytes
  localparam int TILE32_SHIFT = 5;
  localparam int TILE64_SHIFT = 6;

  // tile edge as a shift: 8, 4 or 1 texels
  localparam logic [1:0] EDGE_8 = 2'd3;
  localparam logic [1:0] EDGE_4 = 2'd2;
  localparam logic [1:0] EDGE_1 = 2'd0;

  // formats with 64-byte tiles
  localparam logic [FMT_BITS-1:0] FMT_WIDE_A = 6'h06;
  localparam logic [FMT_BITS-1:0] FMT_WIDE_B = 6'h16;

  // one bit per format code, set where the format uses that tile shape
  localparam logic [63:0] MASK_8X8 = 64'h0001_0001_0000_4101;
  localparam logic [63:0] MASK_8X4 = 64'h0600_0784_0002_0206;
  localparam logic [63:0] MASK_4X4 = 64'h1000_1808_0048_0478;

  typedef struct packed {
    logic [1:0] sx;
    logic [1:0] sy;
    logic       tile64;
  } shape_t;

  typedef struct packed {
    logic                valid;
    logic                active;
    logic [LVL_BITS-1:0] lvl;
  } ctl_t;

  function automatic shape_t shape_of(input logic [FMT_BITS-1:0] fmt);
    shape_t s;
    s.tile64 = (fmt == FMT_WIDE_A) || (fmt == FMT_WIDE_B);
    if (MASK_8X8[fmt]) begin
      s.sx = EDGE_8;
      s.sy = EDGE_8;
    end else if (MASK_8X4[fmt]) begin
      s.sx = EDGE_8;
      s.sy = EDGE_4;
    end else if (MASK_4X4[fmt]) begin
      s.sx = EDGE_4;
      s.sy = EDGE_4;
    end else begin
      s.sx = EDGE_1;
      s.sy = EDGE_1;
    end
    return s;
  endfunction

  // running total plus one level's tile count times tile bytes, clamped
  function automatic logic [ACC_BITS-1:0] sat_acc(input logic [ACC_BITS-1:0] acc,
                                                  input logic [PROD_BITS-1:0] prod,
                                                  input logic tile64);
    logic [SUM_BITS-1:0] sum;
    sum = SUM_BITS'(acc) + (SUM_BITS'(prod) << (tile64 ? TILE64_SHIFT : TILE32_SHIFT));
    if (sum > SUM_BITS'(BYTE_MAX)) begin
      return BYTE_MAX;
    end
    return sum[ACC_BITS-1:0];
  endfunction

endpackage

[hdl/tmcs_if.sv]
// valid/ready channel interfaces for the request and the result
interface tmcs_in_if
  import tmcs_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [15:0]         width;
  logic [15:0]         height;
  logic [FMT_BITS-1:0] format_code;
  logic                mipmap_on;
  logic [LVL_BITS-1:0] level_count;

  modport source(output valid, width, height, format_code, mipmap_on, level_count,
                 input ready);
  modport sink(input valid, width, height, format_code, mipmap_on, level_count,
               output ready);
endinterface

interface tmcs_out_if
  import tmcs_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [ACC_BITS-1:0] byte_size;

  modport source(output valid, byte_size, input ready);
  modport sink(input valid, byte_size, output ready);
endinterface

[hdl/tmcs_cell.sv]
// one mip level cell: folds in the previous level, sizes its own level, halves
module tmcs_cell
  import tmcs_pkg::*;
#(
  parameter int DIM_BITS = DIM_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  shape_t                shape,
  input  ctl_t                  ctl_i,
  input  logic [DIM_BITS-1:0]   w_i,
  input  logic [DIM_BITS-1:0]   h_i,
  input  logic [ACC_BITS-1:0]   acc_i,
  input  logic [2*DIM_BITS-1:0] prod_i,
  output ctl_t                  ctl_o,
  output logic [DIM_BITS-1:0]   w_o,
  output logic [DIM_BITS-1:0]   h_o,
  output logic [ACC_BITS-1:0]   acc_o,
  output logic [2*DIM_BITS-1:0] prod_o
);

  localparam int PW = 2 * DIM_BITS;

  ctl_t                ctl_r, ctl_nxt;
  logic [DIM_BITS-1:0] w_r, w_nxt, h_r, h_nxt;
  logic [ACC_BITS-1:0] acc_r, acc_nxt;
  logic [PW-1:0]       prod_r, prod_nxt;

  logic [DIM_BITS:0]   w_up, h_up;
  logic [DIM_BITS-1:0] tx, ty;
  logic                do_lvl, at_unit;

  always_comb begin
    // round up to whole tiles
    w_up = {1'b0, w_i} + (DIM_BITS+1)'((4'd1 << shape.sx) - 4'd1);
    h_up = {1'b0, h_i} + (DIM_BITS+1)'((4'd1 << shape.sy) - 4'd1);
    tx   = DIM_BITS'(w_up >> shape.sx);
    ty   = DIM_BITS'(h_up >> shape.sy);

    do_lvl  = ctl_i.valid && ctl_i.active;
    at_unit = (w_i == DIM_BITS'(1)) && (h_i == DIM_BITS'(1));

    acc_nxt  = sat_acc(acc_i, PROD_BITS'(prod_i), shape.tile64);
    prod_nxt = do_lvl ? (PW'(tx) * PW'(ty)) : '0;

    ctl_nxt = ctl_i;
    w_nxt   = w_i;
    h_nxt   = h_i;
    if (do_lvl) begin
      ctl_nxt.lvl    = ctl_i.lvl - LVL_BITS'(1);
      ctl_nxt.active = !at_unit && (ctl_i.lvl > LVL_BITS'(1));
      w_nxt = (w_i < DIM_BITS'(2)) ? DIM_BITS'(1) : (w_i >> 1);
      h_nxt = (h_i < DIM_BITS'(2)) ? DIM_BITS'(1) : (h_i >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid  <= 1'b0;
      ctl_r.active <= 1'b0;
    end else if (adv) begin
      ctl_r  <= ctl_nxt;
      w_r    <= w_nxt;
      h_r    <= h_nxt;
      acc_r  <= acc_nxt;
      prod_r <= prod_nxt;
    end
  end

  assign ctl_o  = ctl_r;
  assign w_o    = w_r;
  assign h_o    = h_r;
  assign acc_o  = acc_r;
  assign prod_o = prod_r;

endmodule

[hdl/texture_mip_chain_size.sv]
// top level: tiled texture byte size over a mip chain, one cell per level
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        width, height, format_code, mipmap_on, level_count
//   out_ch   out  valid/ready        byte_size
//
// a request beat is loaded into an entry register, then walks a row of
// DIM_BITS level cells, one cell per cycle while the row is not frozen, and
// lands in the output register; one request is in the row at a time, so the
// next is taken only once the entry register and the cell row are empty.
// reset clears all valid flags.
// a result beat left waiting in the output register freezes the row only
// when the next result reaches the last cell
module texture_mip_chain_size
  import tmcs_pkg::*;
#(
  parameter int DIM_BITS = DIM_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  tmcs_in_if.sink      in_ch,
  tmcs_out_if.source   out_ch
);

  localparam int NC = DIM_BITS;

  ctl_t                  ctl_s  [0:NC];
  logic [DIM_BITS-1:0]   w_s    [0:NC];
  logic [DIM_BITS-1:0]   h_s    [0:NC];
  logic [ACC_BITS-1:0]   acc_s  [0:NC];
  logic [2*DIM_BITS-1:0] prod_s [0:NC];

  ctl_t                ctl0_r;
  logic [DIM_BITS-1:0] w0_r, h0_r;
  shape_t              shape_r;
  logic                out_valid_r;
  logic [ACC_BITS-1:0] out_byte_r;

  logic [NC:0] chain_v;
  logic        busy, adv, in_acc;

  always_comb begin
    for (int i = 0; i <= NC; i++) begin
      chain_v[i] = ctl_s[i].valid;
    end
  end

  assign busy   = |chain_v;
  assign adv    = !(ctl_s[NC].valid && out_valid_r && !out_ch.ready);
  assign in_acc = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !busy;

  // entry register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r.valid  <= 1'b0;
      ctl0_r.active <= 1'b0;
    end else if (in_acc) begin
      ctl0_r.valid  <= 1'b1;
      ctl0_r.active <= !in_ch.mipmap_on || (in_ch.level_count != '0);
      ctl0_r.lvl    <= in_ch.mipmap_on ? in_ch.level_count : LVL_BITS'(1);
      w0_r          <= in_ch.width[DIM_BITS-1:0];
      h0_r          <= in_ch.height[DIM_BITS-1:0];
      shape_r       <= shape_of(in_ch.format_code);
    end else if (adv) begin
      ctl0_r.valid  <= 1'b0;
      ctl0_r.active <= 1'b0;
    end
  end

  assign ctl_s[0]  = ctl0_r;
  assign w_s[0]    = w0_r;
  assign h_s[0]    = h0_r;
  assign acc_s[0]  = '0;
  assign prod_s[0] = '0;

  for (genvar g = 0; g < NC; g++) begin : g_cell
    tmcs_cell #(.DIM_BITS(DIM_BITS)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .shape  (shape_r),
      .ctl_i  (ctl_s[g]),
      .w_i    (w_s[g]),
      .h_i    (h_s[g]),
      .acc_i  (acc_s[g]),
      .prod_i (prod_s[g]),
      .ctl_o  (ctl_s[g+1]),
      .w_o    (w_s[g+1]),
      .h_o    (h_s[g+1]),
      .acc_o  (acc_s[g+1]),
      .prod_o (prod_s[g+1])
    );
  end

  // output register: folds in the last level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl_s[NC].valid && adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_s[NC].valid && adv) begin
      out_byte_r <= sat_acc(acc_s[NC], PROD_BITS'(prod_s[NC]), shape_r.tile64);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.byte_size = out_byte_r;

  // only one request in the row at any time
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(chain_v))
    else $error("more than one request in the cell row");

  // a request reaching the end of the row is held while the result waits
  a_tail_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_s[NC].valid && !adv |=> ctl_s[NC].valid)
    else $error("request left the last cell during a stall");

  // a request leaving the row always lands in the output register
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_s[NC].valid && adv |=> out_valid_r)
    else $error("result lost at the output register");

  // an accepted beat enters the entry register
  a_entry_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> ctl0_r.valid && !ctl_s[NC].valid)
    else $error("accepted beat not in entry register");

endmodule
